### design/spq_pkg.sv
// Shared definitions for the sorted priority queue: operation and status codes,
// field widths and the command struct that drives the cell row. No dependencies.
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int OCC_W  = 5;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // Broadcast to every cell in the row for one cycle.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_cmd_t;

endpackage

### design/sorted_priority_queue_unit.sv
// Sorted priority queue built as a row of DEPTH shift cells, head in cell 0.
// The result strobe comes in the cycle after the transfer is accepted.
// Throughput: one operation per cycle once out of reset; every cell compares and shifts at once.
// Reset (synchronous, rst_n low) empties the queue; busy is high while in reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic signed [spq_pkg::DATA_W-1:0] in_item_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_item_priority,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [spq_pkg::DATA_W-1:0] out_head_data,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Entry count; cell i holds a live entry when i is below the count.
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              busy_r;
  logic              valid_r;
  logic [1:0]        status_r, status_nxt;
  logic [DATA_W-1:0] head_r, head_nxt;

  logic     accept;
  logic     full, empty;
  spq_cmd_t cmd;

  // Neighbor links along the row.
  logic                     lower_w [DEPTH];
  logic [DATA_W-1:0]        data_w  [DEPTH];
  logic signed [PRIO_W-1:0] prio_w  [DEPTH];

  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  // The row only moves on a transfer that actually changes the queue.
  assign cmd.enq = accept && (in_op == OP_ENQ) && !full;
  assign cmd.deq = accept && (in_op == OP_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     up_lower;
    logic [DATA_W-1:0]        up_data;
    logic signed [PRIO_W-1:0] up_prio;
    logic [DATA_W-1:0]        dn_data;
    logic signed [PRIO_W-1:0] dn_prio;

    if (i == 0) begin : g_top
      // Nothing above the head: it never takes a shifted entry.
      assign up_lower = 1'b0;
      assign up_data  = '0;
      assign up_prio  = '0;
    end else begin : g_mid
      assign up_lower = lower_w[i-1];
      assign up_data  = data_w[i-1];
      assign up_prio  = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      // The tail slot becomes free on a dequeue, so its contents do not matter.
      assign dn_data = '0;
      assign dn_prio = '0;
    end else begin : g_inner
      assign dn_data = data_w[i+1];
      assign dn_prio = prio_w[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occ      (CNT_W'(i) < count_r),
      .new_data (in_item_data),
      .new_prio (in_item_priority),
      .up_lower (up_lower),
      .up_data  (up_data),
      .up_prio  (up_prio),
      .dn_data  (dn_data),
      .dn_prio  (dn_prio),
      .lower    (lower_w[i]),
      .data     (data_w[i]),
      .prio     (prio_w[i])
    );
  end

  // Result and count for the operation being accepted this cycle.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    head_nxt   = '0;
    unique case (in_op) inside
      OP_ENQ: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt = data_w[0];
          if (in_op == OP_DEQ) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
        // Unused code: no operation, plain ok status.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload registers need no reset; the strobe qualifies them.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_head_data = head_r;
  assign out_occupancy = OCC_W'(count_r);

endmodule

### design/spq_cell.sv
// One slot of the sorted queue row: holds a (data, priority) pair and loads from
// its upper neighbor, its lower neighbor or the new item. Depends on spq_pkg.
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::spq_cmd_t                 cmd,
  input  logic                              occ,
  input  logic [spq_pkg::DATA_W-1:0]        new_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic                              up_lower,
  input  logic [spq_pkg::DATA_W-1:0]        up_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] up_prio,
  input  logic [spq_pkg::DATA_W-1:0]        dn_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] dn_prio,
  output logic                              lower,
  output logic [spq_pkg::DATA_W-1:0]        data,
  output logic signed [spq_pkg::PRIO_W-1:0] prio
);
  import spq_pkg::*;

  logic [DATA_W-1:0]        data_r, data_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;

  // An empty slot or one of strictly lower priority gives way to the new item.
  // Along the sorted row this flag is a run of zeros followed by ones.
  assign lower = !occ || (prio_r < new_prio);

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (cmd.enq) begin
      if (up_lower) begin
        data_nxt = up_data;
        prio_nxt = up_prio;
      end else if (lower) begin
        data_nxt = new_data;
        prio_nxt = new_prio;
      end
    end else if (cmd.deq) begin
      data_nxt = dn_data;
      prio_nxt = dn_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule

### tb/spq_result_checker.sv
// Result checker for the sorted priority queue: keeps a shadow copy of the queue,
// predicts the reply to every accepted transfer and compares it with the strobed result.
// Depends on spq_pkg for field widths, operation and status codes.
module spq_result_checker #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic signed [spq_pkg::DATA_W-1:0] in_item_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_item_priority,
  input  logic                              out_valid,
  input  logic [1:0]                        out_status,
  input  logic signed [spq_pkg::DATA_W-1:0] out_head_data,
  input  logic [spq_pkg::OCC_W-1:0]         out_occupancy,
  output int                                failures,
  output int                                pending
);
  import spq_pkg::*;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] head_data;
    logic [OCC_W-1:0]         occupancy;
  } queue_reply_t;

  logic signed [DATA_W-1:0] shadow_data [DEPTH];
  logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
  int                       shadow_count;
  queue_reply_t             awaited_replies [$];
  queue_reply_t             oldest_reply;
  int                       fail_tally = 0;

  initial begin
    failures = 0;
    pending  = 0;
    shadow_count = 0;
  end

  // Applies one operation to the shadow queue and returns the reply it should produce.
  function automatic queue_reply_t serve_request(input logic [1:0] op,
                                                 input logic signed [DATA_W-1:0] data,
                                                 input logic signed [PRIO_W-1:0] prio);
    queue_reply_t reply;
    int           slot;
    reply = '0;
    case (op) inside
      OP_ENQ: begin
        if (shadow_count >= DEPTH) begin
          reply.status = ST_OVERFLOW;
        end else begin
          // The new entry goes above the first one of strictly lower priority.
          slot = shadow_count;
          for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_prio[i] < prio) slot = i;
          end
          for (int i = shadow_count; i > slot; i--) begin
            shadow_data[i] = shadow_data[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_data[slot] = data;
          shadow_prio[slot] = prio;
          shadow_count++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (shadow_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.head_data = shadow_data[0];
          if (op == OP_DEQ) begin
            for (int i = 1; i < shadow_count; i++) begin
              shadow_data[i-1] = shadow_data[i];
              shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    reply.occupancy = OCC_W'(shadow_count);
    return reply;
  endfunction

  task automatic report_field(input string field, input longint expected, input longint actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      awaited_replies.delete();
    end else begin
      // The result seen at this edge belongs to an earlier transfer, so it is
      // matched before the transfer accepted at this edge is predicted.
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d data %0d occ %0d",
                   $time, out_status, out_head_data, out_occupancy);
          fail_tally++;
        end else begin
          oldest_reply = awaited_replies.pop_front();
          report_field("status", oldest_reply.status, out_status);
          report_field("head_data", oldest_reply.head_data, out_head_data);
          report_field("occupancy", oldest_reply.occupancy, out_occupancy);
        end
      end
      if (start && !busy) begin
        awaited_replies.push_back(serve_request(in_op, in_item_data, in_item_priority));
      end
    end
    pending  <= awaited_replies.size();
    failures <= fail_tally;
  end

endmodule

### tb/sorted_priority_queue_unit_test.sv
// Top of the sorted priority queue testbench: clock, reset, stimulus and verdict.
// Depends on spq_pkg, the sorted_priority_queue_unit block and spq_result_checker.
module sorted_priority_queue_unit_test;
  import spq_pkg::*;

  localparam int DEPTH = 16;
  // The two-bit op field has one code with no operation behind it.
  localparam logic [1:0] OP_NOP = 2'd3;
  // Number of random transfers that carry a real operation; the unused op code is not counted.
  localparam int RANDOM_ITEMS = 1850;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [1:0]               in_op = OP_NOP;
  logic signed [DATA_W-1:0] in_item_data = '0;
  logic signed [PRIO_W-1:0] in_item_priority = '0;
  logic                     busy;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_head_data;
  logic [OCC_W-1:0]         out_occupancy;
  int                       failures;
  int                       pending;

  // 10 time unit clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_data    (out_head_data),
    .out_occupancy    (out_occupancy)
  );

  // The checker watches both channels on its own and only reports back how many
  // failures it has seen and how many results it is still waiting for.
  spq_result_checker #(
    .DEPTH(DEPTH)
  ) u_result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_item_data     (in_item_data),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_data    (out_head_data),
    .out_occupancy    (out_occupancy),
    .failures         (failures),
    .pending          (pending)
  );

  // Presents one request and holds it until the block takes it. The caller is always
  // just past a rising edge, so the new values land with that edge's updates. The
  // transfer happens at the first later edge where busy was low; busy is read before
  // the block updates it at that edge, which keeps the check free of races.
  task automatic transfer(input logic [1:0] op,
                          input logic signed [DATA_W-1:0] data,
                          input logic signed [PRIO_W-1:0] prio);
    start            <= 1'b1;
    in_op            <= op;
    in_item_data     <= data;
    in_item_priority <= prio;
    do @(posedge clk); while (busy);
  endtask

  // Drops start for an idle gap whose length is the argument. Apart from the final drain,
  // start is only lowered here, never in a cycle where the next request raises it again.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Data is mostly uniform, with the signed extremes and the values around zero
  // coming up often enough to be seen at the head many times.
  function automatic logic signed [DATA_W-1:0] pick_data();
    case ($urandom_range(7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return DATA_W'(int'($urandom_range(0, 2)) - 1);
      default: return $urandom;
    endcase
  endfunction

  // Half of the priorities come from a narrow band so that ties are common and the
  // arrival-order rule for equal priorities is exercised hard.
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return PRIO_W'(int'($urandom_range(0, 3)) - 1);
    if (roll == 5) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    return PRIO_W'($urandom);
  endfunction

  initial begin
    int sent;
    int burst_len;
    int enq_pct;
    int roll;
    logic [1:0] op;

    // Synchronous reset is held from the start, then released once for the whole run.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. An empty queue answers peek and dequeue with the empty status,
    // and the unused op code leaves everything alone.
    transfer(OP_PEEK, 32'sh1234_5678, 16'sh0001);
    transfer(OP_DEQ, 32'sh8765_4321, 16'shffff);
    transfer(OP_NOP, 32'shffff_ffff, 16'shffff);

    // Priority and data extremes, plus two entries of equal priority whose order of
    // arrival has to be kept.
    transfer(OP_ENQ, 32'sh7fff_ffff, 16'sh7fff);
    transfer(OP_ENQ, 32'sh8000_0000, 16'sh8000);
    transfer(OP_ENQ, -32'sd1, 16'sh0000);
    transfer(OP_ENQ, 32'sh0000_0000, 16'sh0000);
    transfer(OP_PEEK, $urandom, PRIO_W'($urandom));
    transfer(OP_DEQ, $urandom, PRIO_W'($urandom));
    transfer(OP_DEQ, $urandom, PRIO_W'($urandom));

    // Fill the queue to the brim with repeating priorities, then push once more to
    // see the overflow status with the contents untouched.
    for (int k = 0; k < DEPTH - 2; k++) begin
      transfer(OP_ENQ, $urandom, PRIO_W'(k % 3));
    end
    transfer(OP_ENQ, 32'sh5555_aaaa, 16'sh7fff);
    transfer(OP_PEEK, 32'sh0, 16'sh0);
    transfer(OP_DEQ, 32'shffff_ffff, 16'sh8000);

    // Random part. The sender works in bursts of random length. The enqueue share
    // drifts between filling, balanced and draining so the occupancy keeps sweeping
    // between empty and full; op code 3 shows up now and then as noise and is not
    // counted.
    sent = 0;
    enq_pct = 50;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 15;
          1: enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      burst_len = $urandom_range(1, 24);
      for (int b = 0; b < burst_len; b++) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          op = OP_NOP;
        end else if (roll < 3 + enq_pct) begin
          op = OP_ENQ;
        end else begin
          op = ($urandom_range(9) < 7) ? OP_DEQ : OP_PEEK;
        end
        // Dequeue and peek get random data and priority too; the block must ignore them.
        transfer(op, pick_data(), pick_priority());
        if (op != OP_NOP) sent++;
      end
      // About a quarter of the bursts run straight into the next one.
      if ($urandom_range(3) != 0) idle_gap($urandom_range(1, 6));
    end

    // Drain: let the last result come back, then keep watching so a stray
    // strobe would still be caught.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
